### hw/rtl/lbleq_pkg.sv
// Shared widths, operation codes and status codes of the label equivalence table.
package lbleq_pkg;

    // Widths of the fixed transaction fields.
    localparam int FUNC_W  = 3;
    localparam int LABEL_W = 10;
    localparam int RES_W   = 10;
    localparam int STAT_W  = 2;

    // Operation codes carried on the func field.
    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC = 3'd0,
        FN_MERGE = 3'd1,
        FN_FLAT  = 3'd2,
        FN_LOOK  = 3'd3,
        FN_CLEAR = 3'd4
    } t_func;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

endpackage

### hw/rtl/label_equivalence_table.sv
// Top level of the label equivalence table: sequencer around one parent-table RAM.
//
// Usage: a transaction is taken at a rising edge with start high and busy low.
// The operation (i_func) is allocate, merge, flatten, lookup or clear; i_label_a
// and i_label_b name the labels. Exactly one result comes back per transaction,
// shown on o_result_value and o_status for one cycle with o_valid high. The
// receiver cannot stall; the result must be taken in that cycle.
// Steps from accept to o_valid:
//   allocate, clear, unused codes and rejected labels: answered from idle;
//   lookup: a parent read, then the answer;
//   merge: a read of each walker's parent per step of the union-find walk;
//   flatten: a check per allocated label, and a parent read per non-root label.
// These steps are set by the single read port of the parent RAM, which the
// sequencer uses once per cycle. busy is high while the sequencer is out of
// idle, until the result cycle, in which a new transaction may already be taken.
// Reset (synchronous, active low) empties the table: the next label is 1.
// The RAM itself is not cleared; only entries of allocated labels are ever used.
module label_equivalence_table
    import lbleq_pkg::*;
#(
    parameter int LABELS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [LABEL_W-1:0] i_label_a,
    input  logic [LABEL_W-1:0] i_label_b,
    output logic               o_valid,
    output logic [RES_W-1:0]   o_result_value,
    output logic [STAT_W-1:0]  o_status
);

    localparam int IW    = $clog2(LABELS);
    localparam int NW    = IW + 1;
    localparam int SW    = $clog2(2 * LABELS) + 1;
    localparam int CMPW  = (NW > LABEL_W) ? NW : LABEL_W;
    localparam logic [NW-1:0] LABELS_N = NW'(LABELS);
    localparam logic [SW-1:0] WALK_MAX = SW'(2 * LABELS);

    // Sequencer states.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MRY  = 6'b000010,
        S_MCMP = 6'b000100,
        S_FCHK = 6'b001000,
        S_FPAR = 6'b010000,
        S_LOOK = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [NW-1:0]       r_next, n_next;
    logic [IW-1:0]       r_rx, n_rx;
    logic [IW-1:0]       r_ry, n_ry;
    logic [IW-1:0]       r_px, n_px;
    logic [SW-1:0]       r_steps, n_steps;
    logic [NW-1:0]       r_idx, n_idx;
    logic [NW-1:0]       r_k, n_k;
    logic                r_valid, n_valid;
    logic [RES_W-1:0]    r_result, n_result;
    logic [STAT_W-1:0]   r_status, n_status;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [IW-1:0]       ram_wdata;
    logic [IW-1:0]       ram_raddr;
    logic [IW-1:0]       ram_rdata;

    logic                acc;
    logic                a_ok, b_ok;
    logic [IW-1:0]       a_idx, b_idx;
    logic [NW-1:0]       idx_inc;
    logic [NW-1:0]       k_inc;

    // Parent table storage.
    lbleq_ram #(
        .WIDTH (IW),
        .DEPTH (LABELS)
    ) u_parent (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake and label checks.
    assign busy    = (r_state != S_IDLE);
    assign acc     = start && !busy;
    assign a_idx   = IW'(i_label_a);
    assign b_idx   = IW'(i_label_b);
    assign a_ok    = (i_label_a != '0) && (CMPW'(i_label_a) < CMPW'(r_next));
    assign b_ok    = (i_label_b != '0) && (CMPW'(i_label_b) < CMPW'(r_next));
    assign idx_inc = r_idx + NW'(1);
    assign k_inc   = r_k + NW'(1);

    // Sequencer: one RAM read and at most one RAM write per cycle.
    always_comb begin
        n_state   = r_state;
        n_next    = r_next;
        n_rx      = r_rx;
        n_ry      = r_ry;
        n_px      = r_px;
        n_steps   = r_steps;
        n_idx     = r_idx;
        n_k       = r_k;
        n_valid   = 1'b0;
        n_result  = r_result;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = r_rx;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_result = '0;
                    n_status = ST_OK;
                    unique case (t_func'(i_func))
                        FN_ALLOC: begin
                            n_valid = 1'b1;
                            if (r_next >= LABELS_N) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = IW'(r_next);
                                ram_wdata = IW'(r_next);
                                n_result  = RES_W'(r_next);
                                n_next    = r_next + NW'(1);
                            end
                        end
                        FN_MERGE: begin
                            if (!(a_ok && b_ok)) begin
                                n_valid  = 1'b1;
                                n_status = ST_BAD;
                            end else begin
                                n_rx      = a_idx;
                                n_ry      = b_idx;
                                n_steps   = '0;
                                ram_raddr = a_idx;
                                n_state   = S_MRY;
                            end
                        end
                        FN_FLAT: begin
                            if (r_next <= NW'(1)) begin
                                n_valid = 1'b1;
                            end else begin
                                n_idx     = NW'(1);
                                n_k       = NW'(1);
                                ram_raddr = IW'(1);
                                n_state   = S_FCHK;
                            end
                        end
                        FN_LOOK: begin
                            if (!a_ok) begin
                                n_valid  = 1'b1;
                                n_status = ST_BAD;
                            end else begin
                                ram_raddr = a_idx;
                                n_state   = S_LOOK;
                            end
                        end
                        FN_CLEAR: begin
                            n_valid = 1'b1;
                            n_next  = NW'(1);
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end

            // Capture the first walker's parent and read the second one's.
            S_MRY: begin
                n_px      = ram_rdata;
                ram_raddr = r_ry;
                n_state   = S_MCMP;
            end

            // Splicing walk step: link the walker with the larger parent to the smaller.
            S_MCMP: begin
                if ((r_px == ram_rdata) || (r_steps >= WALK_MAX)) begin
                    n_valid  = 1'b1;
                    n_result = RES_W'(r_px);
                    n_state  = S_IDLE;
                end else if (r_px > ram_rdata) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_rx;
                    ram_wdata = ram_rdata;
                    if (r_rx == r_px) begin
                        n_valid  = 1'b1;
                        n_result = RES_W'(ram_rdata);
                        n_state  = S_IDLE;
                    end else begin
                        n_rx      = r_px;
                        ram_raddr = r_px;
                        n_steps   = r_steps + SW'(1);
                        n_state   = S_MRY;
                    end
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_ry;
                    ram_wdata = r_px;
                    if (r_ry == ram_rdata) begin
                        n_valid  = 1'b1;
                        n_result = RES_W'(r_px);
                        n_state  = S_IDLE;
                    end else begin
                        n_ry      = ram_rdata;
                        ram_raddr = r_rx;
                        n_steps   = r_steps + SW'(1);
                        n_state   = S_MRY;
                    end
                end
            end

            // Flatten: a root gets the next component number, others follow their parent.
            S_FCHK: begin
                if (NW'(ram_rdata) < r_idx) begin
                    ram_raddr = ram_rdata;
                    n_state   = S_FPAR;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = IW'(r_idx);
                    ram_wdata = IW'(r_k);
                    n_k       = k_inc;
                    n_idx     = idx_inc;
                    if (idx_inc < r_next) begin
                        ram_raddr = IW'(idx_inc);
                        n_state   = S_FCHK;
                    end else begin
                        n_valid  = 1'b1;
                        n_result = RES_W'(r_k);
                        n_state  = S_IDLE;
                    end
                end
            end

            // Flatten: write the parent's already renumbered entry.
            S_FPAR: begin
                ram_we    = 1'b1;
                ram_waddr = IW'(r_idx);
                ram_wdata = ram_rdata;
                n_idx     = idx_inc;
                if (idx_inc < r_next) begin
                    ram_raddr = IW'(idx_inc);
                    n_state   = S_FCHK;
                end else begin
                    n_valid  = 1'b1;
                    n_result = RES_W'(r_k - NW'(1));
                    n_state  = S_IDLE;
                end
            end

            // Lookup answers with the entry just read.
            S_LOOK: begin
                n_valid  = 1'b1;
                n_result = RES_W'(ram_rdata);
                n_status = ST_OK;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_next  <= NW'(1);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_next  <= n_next;
            r_valid <= n_valid;
        end
    end

    // Walk and result registers.
    always_ff @(posedge i_clk) begin
        r_rx     <= n_rx;
        r_ry     <= n_ry;
        r_px     <= n_px;
        r_steps  <= n_steps;
        r_idx    <= n_idx;
        r_k      <= n_k;
        r_result <= n_result;
        r_status <= n_status;
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_result;
    assign o_status       = r_status;

    // A result is only shown once the sequencer is back in idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while sequencer busy");

    // The allocation counter stays between one and the table size.
    a_next_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next != '0) && (r_next <= LABELS_N))
        else $error("next label out of range");

    // Writes only touch allocated entries or the one being allocated.
    a_write_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (NW'(ram_waddr) <= r_next))
        else $error("write beyond allocated labels");

    // An allocate with room answers next cycle and bumps the counter.
    a_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_func == FN_ALLOC) && (r_next < LABELS_N)) |=>
            (o_valid && (o_status == ST_OK) && (r_next == $past(r_next) + NW'(1))))
        else $error("allocate did not complete");

    // A clear answers next cycle with an empty table.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_func == FN_CLEAR)) |=> (o_valid && (r_next == NW'(1))))
        else $error("clear did not complete");

endmodule

### hw/rtl/lbleq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module lbleq_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
